@@ rtl/hx20_pkg.sv @@
// Shared types, constants and the node position table for the hexa20
// shape function pipeline. No dependencies.
package hx20_pkg;

  // Fixed point format of the coordinates and the result
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 18;
  localparam int OUT_W     = 24;
  localparam int NUM_NODES = 20;

  // Factor width: covers the largest linear factor with headroom
  localparam int FAC_W  = ((FRAC_BITS >= COORD_W) ? FRAC_BITS + 2 : COORD_W) + 4;
  localparam int LO_W   = FAC_W;
  localparam int PROD_W = 4 * FAC_W;

  typedef logic signed [FAC_W-1:0] fac_t;

  localparam fac_t ONE      = FAC_W'(64'd1 << FRAC_BITS);
  localparam fac_t FIVE_ONE = FAC_W'(64'd5 << FRAC_BITS);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Mode and axis codes
  localparam logic       MODE_VALUE = 1'b0;
  localparam logic       MODE_DERIV = 1'b1;
  localparam logic [1:0] AX_R    = 2'd0;
  localparam logic [1:0] AX_S    = 2'd1;
  localparam logic [1:0] AX_T    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;

  // Node position per axis: +1, -1 or 0
  localparam logic [1:0] NP = 2'b01;
  localparam logic [1:0] NM = 2'b11;
  localparam logic [1:0] NZ = 2'b00;

  typedef logic [2:0][1:0] node_pos_t;

  // Final scaling: right shift applied to the exact product
  typedef enum logic [1:0] {
    SH_EDGE_AXIS = 2'd1,  // 3*FRAC_BITS + 1
    SH_EDGE      = 2'd2,  // 3*FRAC_BITS + 2
    SH_CORNER    = 2'd3   // 3*FRAC_BITS + 3
  } shift_code_t;

  typedef struct packed {
    fac_t        f0;
    fac_t        f1;
    fac_t        f2;
    fac_t        f3;
    shift_code_t sh;
  } factor_t;

  // Node positions, packed as {t, s, r}
  function automatic node_pos_t node_pos(input logic [4:0] node);
    node_pos_t p;
    case (node)
      5'd0:    p = {NM, NM, NM};
      5'd1:    p = {NM, NM, NP};
      5'd2:    p = {NM, NP, NP};
      5'd3:    p = {NM, NP, NM};
      5'd4:    p = {NP, NM, NM};
      5'd5:    p = {NP, NM, NP};
      5'd6:    p = {NP, NP, NP};
      5'd7:    p = {NP, NP, NM};
      5'd8:    p = {NM, NM, NZ};
      5'd9:    p = {NM, NZ, NM};
      5'd10:   p = {NZ, NM, NM};
      5'd11:   p = {NM, NZ, NP};
      5'd12:   p = {NZ, NM, NP};
      5'd13:   p = {NM, NP, NZ};
      5'd14:   p = {NZ, NP, NP};
      5'd15:   p = {NZ, NP, NM};
      5'd16:   p = {NP, NM, NZ};
      5'd17:   p = {NP, NZ, NM};
      5'd18:   p = {NP, NZ, NP};
      5'd19:   p = {NP, NP, NZ};
      default: p = {NZ, NZ, NZ};
    endcase
    return p;
  endfunction

endpackage

@@ rtl/hx20_factor_gen.sv @@
// Builds the four signed factors and the output scaling of one item.
// Depends on hx20_pkg.
module hx20_factor_gen (
  input  logic                               mode,
  input  logic [4:0]                         node_index,
  input  logic [1:0]                         direction,
  input  logic signed [hx20_pkg::COORD_W-1:0] coord_r,
  input  logic signed [hx20_pkg::COORD_W-1:0] coord_s,
  input  logic signed [hx20_pkg::COORD_W-1:0] coord_t,
  output hx20_pkg::factor_t                  fac
);

  hx20_pkg::node_pos_t npos;
  hx20_pkg::fac_t      qv  [3];
  hx20_pkg::fac_t      lin [3];
  hx20_pkg::fac_t      sum_c;
  hx20_pkg::fac_t      qe;
  logic [1:0]          e, k, kn, kp, o1, o2, o;
  logic                corner, zero;

  function automatic hx20_pkg::fac_t sel3(input hx20_pkg::fac_t v [3], input logic [1:0] i);
    hx20_pkg::fac_t r;
    case (i)
      hx20_pkg::AX_R: r = v[0];
      hx20_pkg::AX_S: r = v[1];
      default:        r = v[2];
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nxt(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      hx20_pkg::AX_R: r = hx20_pkg::AX_S;
      hx20_pkg::AX_S: r = hx20_pkg::AX_T;
      default:        r = hx20_pkg::AX_R;
    endcase
    return r;
  endfunction

  function automatic hx20_pkg::fac_t flip(input hx20_pkg::fac_t x, input logic [1:0] np);
    return (np == hx20_pkg::NM) ? -x : x;
  endfunction

  always_comb begin
    npos  = hx20_pkg::node_pos(node_index);
    qv[0] = hx20_pkg::FAC_W'(coord_r);
    qv[1] = hx20_pkg::FAC_W'(coord_s);
    qv[2] = hx20_pkg::FAC_W'(coord_t);

    // Linear terms 1 + n*x per axis
    for (int d = 0; d < 3; d++) begin
      case (npos[d])
        hx20_pkg::NP: lin[d] = hx20_pkg::ONE + qv[d];
        hx20_pkg::NM: lin[d] = hx20_pkg::ONE - qv[d];
        default:      lin[d] = hx20_pkg::ONE;
      endcase
    end

    // Corner term n.x - 2, written through the linear terms
    sum_c = lin[0] + lin[1] + lin[2] - hx20_pkg::FIVE_ONE;

    // Edge axis of a midside node
    if (npos[0] == hx20_pkg::NZ) begin
      e = hx20_pkg::AX_R;
    end else if (npos[1] == hx20_pkg::NZ) begin
      e = hx20_pkg::AX_S;
    end else if (npos[2] == hx20_pkg::NZ) begin
      e = hx20_pkg::AX_T;
    end else begin
      e = hx20_pkg::AX_R;
    end
    corner = (npos[0] != hx20_pkg::NZ) && (npos[1] != hx20_pkg::NZ) &&
             (npos[2] != hx20_pkg::NZ);

    k  = (direction == hx20_pkg::AX_NONE) ? hx20_pkg::AX_R : direction;
    kn = nxt(k);
    kp = nxt(kn);
    o1 = nxt(e);
    o2 = nxt(o1);
    o  = (o1 == k) ? o2 : o1;
    qe = sel3(qv, e);

    zero = (node_index > 5'(hx20_pkg::NUM_NODES - 1)) ||
           ((mode == hx20_pkg::MODE_DERIV) && (direction == hx20_pkg::AX_NONE));

    fac.f0 = hx20_pkg::ONE;
    fac.f1 = hx20_pkg::ONE;
    fac.f2 = hx20_pkg::ONE;
    fac.f3 = hx20_pkg::ONE;
    fac.sh = hx20_pkg::SH_CORNER;

    // Select factors by node class and mode
    if (corner) begin
      if (mode == hx20_pkg::MODE_VALUE) begin
        fac.f0 = lin[0];
        fac.f1 = lin[1];
        fac.f2 = lin[2];
        fac.f3 = sum_c;
      end else begin
        fac.f0 = sel3(lin, kn);
        fac.f1 = sel3(lin, kp);
        fac.f2 = flip(sum_c + sel3(lin, k), npos[k]);
      end
      fac.sh = hx20_pkg::SH_CORNER;
    end else if (mode == hx20_pkg::MODE_VALUE) begin
      fac.f0 = hx20_pkg::ONE - qe;
      fac.f1 = hx20_pkg::ONE + qe;
      fac.f2 = sel3(lin, o1);
      fac.f3 = sel3(lin, o2);
      fac.sh = hx20_pkg::SH_EDGE;
    end else if (k == e) begin
      fac.f0 = -qe;
      fac.f1 = sel3(lin, o1);
      fac.f2 = sel3(lin, o2);
      fac.sh = hx20_pkg::SH_EDGE_AXIS;
    end else begin
      fac.f0 = hx20_pkg::ONE - qe;
      fac.f1 = hx20_pkg::ONE + qe;
      fac.f2 = flip(sel3(lin, o), npos[k]);
      fac.sh = hx20_pkg::SH_EDGE;
    end

    // Out-of-range node or axis: force the product to zero
    if (zero) begin
      fac.f0 = '0;
    end
  end

endmodule

@@ rtl/hx20_round_sat.sv @@
// Rounds the exact product to nearest (ties away from zero) and saturates
// it to the output width. Depends on hx20_pkg.
module hx20_round_sat (
  input  logic signed [hx20_pkg::PROD_W-1:0] prod,
  input  hx20_pkg::shift_code_t              sh,
  output logic signed [hx20_pkg::OUT_W-1:0]  value,
  output logic                               sat
);

  localparam int WIDE_W = hx20_pkg::PROD_W + 1;
  localparam int S_AX   = 3 * hx20_pkg::FRAC_BITS + 1;
  localparam int S_ED   = 3 * hx20_pkg::FRAC_BITS + 2;
  localparam int S_CO   = 3 * hx20_pkg::FRAC_BITS + 3;
  localparam int RND_W  = hx20_pkg::PROD_W - 3 * hx20_pkg::FRAC_BITS;

  logic signed [WIDE_W-1:0] wide, half, biased, shifted;
  logic signed [RND_W-1:0]  rounded;

  always_comb begin
    wide = WIDE_W'(prod);
    case (sh)
      hx20_pkg::SH_EDGE_AXIS: half = WIDE_W'(1) <<< (S_AX - 1);
      hx20_pkg::SH_EDGE:      half = WIDE_W'(1) <<< (S_ED - 1);
      default:                half = WIDE_W'(1) <<< (S_CO - 1);
    endcase

    // Negative values take half minus one, so ties round away from zero
    biased = wide + half - WIDE_W'(prod[hx20_pkg::PROD_W-1]);

    case (sh)
      hx20_pkg::SH_EDGE_AXIS: shifted = biased >>> S_AX;
      hx20_pkg::SH_EDGE:      shifted = biased >>> S_ED;
      default:                shifted = biased >>> S_CO;
    endcase
    rounded = shifted[RND_W-1:0];

    // Clip to the output range
    if (rounded > RND_W'(hx20_pkg::OUT_MAX)) begin
      value = hx20_pkg::OUT_MAX;
      sat   = 1'b1;
    end else if (rounded < RND_W'(hx20_pkg::OUT_MIN)) begin
      value = hx20_pkg::OUT_MIN;
      sat   = 1'b1;
    end else begin
      value = rounded[hx20_pkg::OUT_W-1:0];
      sat   = 1'b0;
    end
  end

endmodule

@@ rtl/hexa20_shape_function_eval.sv @@
// Top level of the 20-node serendipity hexahedron shape function pipeline.
// Depends on hx20_pkg, hx20_factor_gen and hx20_round_sat.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one evaluation item: mode,
//   node_index, direction and the coordinates coord_r/s/t. Output channel
//   (out_valid/out_ready) returns one item per input: result_value and the
//   saturated flag.
//   The pipeline has five register stages: factor build, two pairwise
//   products, the split 44x22 partial products, their sum, and the rounded
//   and clipped output register. Throughput is one item per cycle while
//   out_ready stays high.
//   Each stage loads whenever it is empty or the stage after it moves, so
//   bubbles close up and input is taken while a result waits at the output.
//   When out_ready is low the output holds and upstream stages fill; in_ready
//   drops only once every stage holds an item.
//   Reset clears all valid bits; data registers are not reset.
module hexa20_shape_function_eval (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [4:0]                          node_index,
  input  logic [1:0]                          direction,
  input  logic signed [hx20_pkg::COORD_W-1:0] coord_r,
  input  logic signed [hx20_pkg::COORD_W-1:0] coord_s,
  input  logic signed [hx20_pkg::COORD_W-1:0] coord_t,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hx20_pkg::OUT_W-1:0]   result_value,
  output logic                                saturated
);

  localparam int FAC_W = hx20_pkg::FAC_W;
  localparam int LO_W  = hx20_pkg::LO_W;
  localparam int LO3_W = 2 * FAC_W + LO_W + 1;
  localparam int HI3_W = 3 * FAC_W;

  hx20_pkg::factor_t fac_in, fac1;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  logic signed [2*FAC_W-1:0]          p2, g2;
  hx20_pkg::shift_code_t              sh2, sh3, sh4;
  logic signed [LO3_W-1:0]            lo3;
  logic signed [HI3_W-1:0]            hi3;
  logic signed [hx20_pkg::PROD_W-1:0] prod4;
  logic signed [hx20_pkg::OUT_W-1:0]  value_rnd;
  logic                               sat_rnd;

  hx20_factor_gen u_factor (
    .mode       (mode),
    .node_index (node_index),
    .direction  (direction),
    .coord_r    (coord_r),
    .coord_s    (coord_s),
    .coord_t    (coord_t),
    .fac        (fac_in)
  );

  hx20_round_sat u_round (
    .prod  (prod4),
    .sh    (sh4),
    .value (value_rnd),
    .sat   (sat_rnd)
  );

  // Advance a stage when it is empty or its successor moves
  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // Data path stages
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      fac1 <= fac_in;
    end
    if (en2 && v1) begin
      p2  <= fac1.f0 * fac1.f1;
      g2  <= fac1.f2 * fac1.f3;
      sh2 <= fac1.sh;
    end
    if (en3 && v2) begin
      lo3 <= p2 * $signed({1'b0, g2[LO_W-1:0]});
      hi3 <= p2 * $signed(g2[2*FAC_W-1:LO_W]);
      sh3 <= sh2;
    end
    if (en4 && v3) begin
      prod4 <= (hx20_pkg::PROD_W'(hi3) <<< LO_W) + hx20_pkg::PROD_W'(lo3);
      sh4   <= sh3;
    end
    if (en5 && v4) begin
      result_value <= value_rnd;
      saturated    <= sat_rnd;
    end
  end

`ifndef SYNTH
  // A clipped result sits at one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (result_value == hx20_pkg::OUT_MAX || result_value == hx20_pkg::OUT_MIN))
    else $error("saturated result not at a range limit");

  // An empty output stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // Reset leaves no item at the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
